[hw/rtl/tps_pkg.sv]
// ----------------------------------------------------------------------------
// tps_pkg
// Shared constants for the triangle/plane slicer: field widths, register
// indexes, reset values and queue sizing.
// ----------------------------------------------------------------------------
package tps_pkg;

  // default coordinate width (signed Q16.16)
  localparam int COORD_BITS_DEF = 32;
  // plane normal components, signed Q1.16
  localparam int NORM_BITS      = 18;
  // distance growth over a coordinate: normal width, diff sign, sum of three
  localparam int DIST_EXTRA     = NORM_BITS + 3;
  // lanes: segment a x/y/z, then segment b x/y/z
  localparam int LANES          = 6;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_Y   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_Z   = 3'd5;

  // reset normal points along +z (1.0 in Q1.16)
  localparam logic [NORM_BITS-1:0] NORMAL_Z_RESET = 18'h10000;

  // front/back decoupling queue
  localparam int QUEUE_DEPTH = 2;

endpackage

[hw/rtl/triangle_plane_slicer.sv]
// ----------------------------------------------------------------------------
// triangle_plane_slicer
// Intersects one triangle per beat with a configured plane and returns the
// hit flag and the two segment endpoints in Q16.16.
// ----------------------------------------------------------------------------
//  channel   signals                                   direction  handshake
//  ------    ----------------------------------------  ---------  ----------------
//  input     v0_x_i .. v2_z_i                          in         start & !busy
//  result    hit_o, seg_a_x_o .. seg_b_z_o             out        done_o strobe
//  config    cfg_index_i, cfg_data_i                   in         cfg_valid_i & cfg_ready_o
//
//  One triangle is taken per cycle. A result strobes on done_o after the front
//  stages, queue, partial products, divider (one quotient bit per stage) and
//  output register. Reset clears the plane to normal +z through the origin
//  and empties the pipeline. The result side has no stall; the queue between
//  front and back drains every cycle, so busy stays low.
// ----------------------------------------------------------------------------
module triangle_plane_slicer #(
  parameter int COORD_BITS = tps_pkg::COORD_BITS_DEF,
  parameter int CFG_BITS   = (COORD_BITS > tps_pkg::NORM_BITS) ? COORD_BITS
                                                               : tps_pkg::NORM_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [COORD_BITS-1:0]         v0_x_i,
  input  logic [COORD_BITS-1:0]         v0_y_i,
  input  logic [COORD_BITS-1:0]         v0_z_i,
  input  logic [COORD_BITS-1:0]         v1_x_i,
  input  logic [COORD_BITS-1:0]         v1_y_i,
  input  logic [COORD_BITS-1:0]         v1_z_i,
  input  logic [COORD_BITS-1:0]         v2_x_i,
  input  logic [COORD_BITS-1:0]         v2_y_i,
  input  logic [COORD_BITS-1:0]         v2_z_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tps_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_BITS-1:0]           cfg_data_i,
  output logic                          done_o,
  output logic                          hit_o,
  output logic [COORD_BITS-1:0]         seg_a_x_o,
  output logic [COORD_BITS-1:0]         seg_a_y_o,
  output logic [COORD_BITS-1:0]         seg_a_z_o,
  output logic [COORD_BITS-1:0]         seg_b_x_o,
  output logic [COORD_BITS-1:0]         seg_b_y_o,
  output logic [COORD_BITS-1:0]         seg_b_z_o
);

  localparam int LN  = tps_pkg::LANES;
  localparam int CW  = COORD_BITS;
  localparam int DW  = COORD_BITS + tps_pkg::DIST_EXTRA;
  localparam int EW  = 1 + LN + 2 * LN * CW + DW + 2 * (DW + 1);

  logic                      accept;
  logic [2:0][2:0][CW-1:0]   vert;

  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  assign vert[0] = {v0_z_i, v0_y_i, v0_x_i};
  assign vert[1] = {v1_z_i, v1_y_i, v1_x_i};
  assign vert[2] = {v2_z_i, v2_y_i, v2_x_i};

  // front: plane registers, distances, classification
  logic                  f_push, f_hit;
  logic [LN-1:0]         f_neg;
  logic [LN-1:0][CW-1:0] f_base, f_mag;
  logic [DW-1:0]         f_da;
  logic [1:0][DW:0]      f_den;

  tps_front #(
    .COORD_BITS (COORD_BITS),
    .CFG_BITS   (CFG_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .start_i     (accept),
    .vert_i      (vert),
    .push_o      (f_push),
    .hit_o       (f_hit),
    .neg_o       (f_neg),
    .base_o      (f_base),
    .mag_o       (f_mag),
    .da_o        (f_da),
    .den_o       (f_den)
  );

  // decoupling queue
  logic [EW-1:0]         q_wdata, q_rdata;
  logic                  q_valid, q_full;
  logic                  b_hit;
  logic [LN-1:0]         b_neg;
  logic [LN-1:0][CW-1:0] b_base, b_mag;
  logic [DW-1:0]         b_da;
  logic [1:0][DW:0]      b_den;

  assign q_wdata = {f_hit, f_neg, f_base, f_mag, f_da, f_den};
  assign {b_hit, b_neg, b_base, b_mag, b_da, b_den} = q_rdata;

  tps_queue #(
    .WIDTH (EW),
    .DEPTH (tps_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .data_i  (q_wdata),
    .pop_i   (q_valid),
    .valid_o (q_valid),
    .data_o  (q_rdata),
    .full_o  (q_full)
  );

  assign busy = q_full;

  // back: interpolation
  logic [LN-1:0][CW-1:0] seg;

  tps_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .hit_i   (b_hit),
    .neg_i   (b_neg),
    .base_i  (b_base),
    .mag_i   (b_mag),
    .da_i    (b_da),
    .den_i   (b_den),
    .done_o  (done_o),
    .hit_o   (hit_o),
    .seg_o   (seg)
  );

  assign seg_a_x_o = seg[0];
  assign seg_a_y_o = seg[1];
  assign seg_a_z_o = seg[2];
  assign seg_b_x_o = seg[3];
  assign seg_b_y_o = seg[4];
  assign seg_b_z_o = seg[5];

endmodule

[hw/rtl/tps_queue.sv]
// ----------------------------------------------------------------------------
// tps_queue
// Small register FIFO between the classify front end and the divide back end.
// ----------------------------------------------------------------------------
module tps_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = tps_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_ptr_q];
  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == CntW'(DEPTH));

`ifndef SYNTHESIS
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("queue push while full");
  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("queue pop while empty");
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("queue count beyond depth");
  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count did not advance on push");
`endif

endmodule

[hw/rtl/tps_front.sv]
// ----------------------------------------------------------------------------
// tps_front
// Plane registers, signed vertex distances and case classification. Emits,
// per lane, a base point, an edge delta magnitude, a sign and the divide
// operands; touching and no-hit cases reduce to a zero numerator.
// ----------------------------------------------------------------------------
module tps_front #(
  parameter int COORD_BITS = tps_pkg::COORD_BITS_DEF,
  parameter int CFG_BITS   = (COORD_BITS > tps_pkg::NORM_BITS) ? COORD_BITS
                                                               : tps_pkg::NORM_BITS,
  localparam int DistW     = COORD_BITS + tps_pkg::DIST_EXTRA
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [tps_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_BITS-1:0]                    cfg_data_i,
  input  logic                                   start_i,
  input  logic [2:0][2:0][COORD_BITS-1:0]        vert_i,
  output logic                                   push_o,
  output logic                                   hit_o,
  output logic [tps_pkg::LANES-1:0]              neg_o,
  output logic [tps_pkg::LANES-1:0][COORD_BITS-1:0] base_o,
  output logic [tps_pkg::LANES-1:0][COORD_BITS-1:0] mag_o,
  output logic [DistW-1:0]                       da_o,
  output logic [1:0][DistW:0]                    den_o
);

  localparam int NB    = tps_pkg::NORM_BITS;
  localparam int CW    = COORD_BITS;
  localparam int DW    = DistW;
  localparam int ProdW = CW + NB + 1;
  localparam int O1 [3] = '{1, 2, 0};
  localparam int O2 [3] = '{2, 0, 1};

  // plane registers
  logic [2:0][NB-1:0] normal_q;
  logic [2:0][CW-1:0] point_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      normal_q[0] <= '0;
      normal_q[1] <= '0;
      normal_q[2] <= tps_pkg::NORMAL_Z_RESET;
      point_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tps_pkg::CFG_NORMAL_X: normal_q[0] <= cfg_data_i[NB-1:0];
        tps_pkg::CFG_NORMAL_Y: normal_q[1] <= cfg_data_i[NB-1:0];
        tps_pkg::CFG_NORMAL_Z: normal_q[2] <= cfg_data_i[NB-1:0];
        tps_pkg::CFG_POINT_X:  point_q[0]  <= cfg_data_i[CW-1:0];
        tps_pkg::CFG_POINT_Y:  point_q[1]  <= cfg_data_i[CW-1:0];
        tps_pkg::CFG_POINT_Z:  point_q[2]  <= cfg_data_i[CW-1:0];
        default: ;
      endcase
    end
  end

  // stage valids
  logic vld0_q, vld1_q, vld2_q, vld3_q, vld4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
    end else begin
      vld0_q <= start_i;
      vld1_q <= vld0_q;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
      vld4_q <= vld3_q;
    end
  end

  // payload pipeline
  logic [2:0][2:0][CW-1:0]    v0_q, v1_q, v2_q, v3_q;
  logic [2:0][2:0][CW:0]      diff1_q, diff1_d;
  logic [2:0][2:0][ProdW-1:0] prod2_q, prod2_d;
  logic [2:0][DW-1:0]         dist3_q, dist3_d;

  // v - p, n * (v - p), and the per-vertex sum
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        diff1_d[i][k] = $signed({v0_q[i][k][CW-1], v0_q[i][k]})
                      - $signed({point_q[k][CW-1], point_q[k]});
        // both operands sign-extended to the full product width
        prod2_d[i][k] = $signed({{(ProdW-NB){normal_q[k][NB-1]}}, normal_q[k]})
                      * $signed({{NB{diff1_q[i][k][CW]}}, diff1_q[i][k]});
      end
      dist3_d[i] = $signed({{2{prod2_q[i][0][ProdW-1]}}, prod2_q[i][0]})
                 + $signed({{2{prod2_q[i][1][ProdW-1]}}, prod2_q[i][1]})
                 + $signed({{2{prod2_q[i][2][ProdW-1]}}, prod2_q[i][2]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v0_q <= vert_i;
    end
    v1_q    <= v0_q;
    diff1_q <= diff1_d;
    v2_q    <= v1_q;
    prod2_q <= prod2_d;
    v3_q    <= v2_q;
    dist3_q <= dist3_d;
  end

  // classification
  logic [2:0]                      zr, ng;
  logic                            found;
  logic [1:0]                      lone;
  logic [DW-1:0]                   dl, dea, deb;
  logic [2:0][CW-1:0]              vl, vea, veb;
  logic [DW:0]                     dena, denb;
  logic [DW-1:0]                   dl_abs;
  logic [DW:0]                     dena_abs, denb_abs;
  logic [tps_pkg::LANES-1:0][CW:0] dlt, dmag;
  logic                            hit_d;
  logic [tps_pkg::LANES-1:0]       neg_d;
  logic [tps_pkg::LANES-1:0][CW-1:0] base_d, mag_d;
  logic [DW-1:0]                   da_d;
  logic [1:0][DW:0]                den_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      zr[i] = (dist3_q[i] == '0);
      ng[i] = dist3_q[i][DW-1];
    end

    // first vertex alone on its side, zero counting as either side
    found = 1'b0;
    lone  = 2'd0;
    for (int i = 0; i < 3; i++) begin
      if (!found &&
          ((!ng[i] && (zr[O1[i]] || ng[O1[i]]) && (zr[O2[i]] || ng[O2[i]])) ||
           ((zr[i] || ng[i]) && !ng[O1[i]] && !ng[O2[i]]))) begin
        found = 1'b1;
        lone  = 2'(i);
      end
    end

    // lone vertex and the far ends of both its edges
    case (lone)
      2'd0: begin
        vl = v3_q[0]; vea = v3_q[2]; veb = v3_q[1];
        dl = dist3_q[0]; dea = dist3_q[2]; deb = dist3_q[1];
      end
      2'd1: begin
        vl = v3_q[1]; vea = v3_q[2]; veb = v3_q[0];
        dl = dist3_q[1]; dea = dist3_q[2]; deb = dist3_q[0];
      end
      default: begin
        vl = v3_q[2]; vea = v3_q[0]; veb = v3_q[1];
        dl = dist3_q[2]; dea = dist3_q[0]; deb = dist3_q[1];
      end
    endcase

    dena     = $signed({dl[DW-1], dl}) - $signed({dea[DW-1], dea});
    denb     = $signed({dl[DW-1], dl}) - $signed({deb[DW-1], deb});
    dl_abs   = dl[DW-1] ? (~dl + 1'b1) : dl;
    dena_abs = dena[DW] ? (~dena + 1'b1) : dena;
    denb_abs = denb[DW] ? (~denb + 1'b1) : denb;

    for (int k = 0; k < 3; k++) begin
      dlt[k]     = $signed({vea[k][CW-1], vea[k]}) - $signed({vl[k][CW-1], vl[k]});
      dlt[3 + k] = $signed({veb[k][CW-1], veb[k]}) - $signed({vl[k][CW-1], vl[k]});
    end
    for (int l = 0; l < tps_pkg::LANES; l++) begin
      dmag[l] = dlt[l][CW] ? (~dlt[l] + 1'b1) : dlt[l];
    end

    // defaults give a zero point with a harmless divisor
    hit_d    = 1'b0;
    neg_d    = '0;
    base_d   = '0;
    mag_d    = '0;
    da_d     = '0;
    den_d[0] = (DW + 1)'(1);
    den_d[1] = (DW + 1)'(1);

    if (zr == 3'b111) begin
      // triangle lies in the plane: no hit
      hit_d = 1'b0;
    end else if (zr[0] && zr[1]) begin
      hit_d = 1'b1;
      for (int k = 0; k < 3; k++) begin
        base_d[k] = v3_q[0][k]; base_d[3 + k] = v3_q[1][k];
      end
    end else if (zr[0] && zr[2]) begin
      hit_d = 1'b1;
      for (int k = 0; k < 3; k++) begin
        base_d[k] = v3_q[0][k]; base_d[3 + k] = v3_q[2][k];
      end
    end else if (zr[1] && zr[2]) begin
      hit_d = 1'b1;
      for (int k = 0; k < 3; k++) begin
        base_d[k] = v3_q[1][k]; base_d[3 + k] = v3_q[2][k];
      end
    end else if (found) begin
      hit_d    = 1'b1;
      da_d     = dl_abs;
      den_d[0] = dena_abs;
      den_d[1] = denb_abs;
      for (int k = 0; k < 3; k++) begin
        base_d[k]     = vl[k];
        base_d[3 + k] = vl[k];
        mag_d[k]      = dmag[k][CW-1:0];
        mag_d[3 + k]  = dmag[3 + k][CW-1:0];
        neg_d[k]      = dlt[k][CW] ^ dl[DW-1] ^ dena[DW];
        neg_d[3 + k]  = dlt[3 + k][CW] ^ dl[DW-1] ^ denb[DW];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hit_o  <= hit_d;
    neg_o  <= neg_d;
    base_o <= base_d;
    mag_o  <= mag_d;
    da_o   <= da_d;
    den_o  <= den_d;
  end

  assign push_o = vld4_q;

endmodule

[hw/rtl/tps_back.sv]
// ----------------------------------------------------------------------------
// tps_back
// Interpolation back end: split multiply of |d| by |delta|, a restoring
// divider with one quotient bit per stage on six lanes, round half up, and
// the final add to or subtract from the base point.
// ----------------------------------------------------------------------------
module tps_back #(
  parameter int COORD_BITS = tps_pkg::COORD_BITS_DEF,
  localparam int DistW     = COORD_BITS + tps_pkg::DIST_EXTRA
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      valid_i,
  input  logic                                      hit_i,
  input  logic [tps_pkg::LANES-1:0]                 neg_i,
  input  logic [tps_pkg::LANES-1:0][COORD_BITS-1:0] base_i,
  input  logic [tps_pkg::LANES-1:0][COORD_BITS-1:0] mag_i,
  input  logic [DistW-1:0]                          da_i,
  input  logic [1:0][DistW:0]                       den_i,
  output logic                                      done_o,
  output logic                                      hit_o,
  output logic [tps_pkg::LANES-1:0][COORD_BITS-1:0] seg_o
);

  localparam int LN  = tps_pkg::LANES;
  localparam int CW  = COORD_BITS;
  localparam int DW  = DistW;
  localparam int LB  = (DW + 1) / 2;
  localparam int HB  = DW - LB;
  localparam int NW  = DW + CW;
  localparam int RW  = DW + 1;
  localparam int NST = CW;

  // partial products
  logic                          mvld_q;
  logic [LN-1:0][LB+CW-1:0]      plo_q;
  logic [LN-1:0][HB+CW-1:0]      phi_q;
  logic                          mhit_q;
  logic [LN-1:0]                 mneg_q;
  logic [LN-1:0][CW-1:0]         mbase_q;
  logic [LN-1:0][RW-1:0]         mden_q;

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < LN; l++) begin
      plo_q[l]   <= (LB + CW)'(da_i[LB-1:0]) * (LB + CW)'(mag_i[l]);
      phi_q[l]   <= (HB + CW)'(da_i[DW-1:LB]) * (HB + CW)'(mag_i[l]);
      mden_q[l]  <= (l < 3) ? den_i[0] : den_i[1];
    end
    mhit_q  <= hit_i;
    mneg_q  <= neg_i;
    mbase_q <= base_i;
  end

  // divider stage registers; stage 0 holds the loaded numerator
  logic                     vld_q  [NST+1];
  logic [LN-1:0][RW-1:0]    rem_q  [NST+1];
  logic [LN-1:0][CW-1:0]    low_q  [NST+1];
  logic [LN-1:0][CW-1:0]    quo_q  [NST+1];
  logic [LN-1:0][RW-1:0]    den_q  [NST+1];
  logic [LN-1:0][CW-1:0]    base_q [NST+1];
  logic [LN-1:0]            neg_q  [NST+1];
  logic                     hit_q  [NST+1];

  logic [LN-1:0][NW-1:0]    num_d;
  logic [LN-1:0][RW-1:0]    rem_d  [NST];
  logic [LN-1:0][CW-1:0]    quo_d  [NST];
  logic [RW:0]              trial  [NST][LN];
  logic                     fits   [NST][LN];

  // numerator assembly and one quotient bit per stage
  always_comb begin
    for (int l = 0; l < LN; l++) begin
      num_d[l] = NW'(plo_q[l]) + (NW'(phi_q[l]) << LB);
    end
    for (int s = 0; s < NST; s++) begin
      for (int l = 0; l < LN; l++) begin
        trial[s][l] = {rem_q[s][l], low_q[s][l][CW-1]};
        fits[s][l]  = (trial[s][l] >= {1'b0, den_q[s][l]});
        rem_d[s][l] = fits[s][l] ? RW'(trial[s][l] - {1'b0, den_q[s][l]})
                                 : RW'(trial[s][l]);
        quo_d[s][l] = {quo_q[s][l][CW-2:0], fits[s][l]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mvld_q <= 1'b0;
      for (int s = 0; s <= NST; s++) begin
        vld_q[s] <= 1'b0;
      end
    end else begin
      mvld_q   <= valid_i;
      vld_q[0] <= mvld_q;
      for (int s = 0; s < NST; s++) begin
        vld_q[s + 1] <= vld_q[s];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < LN; l++) begin
      rem_q[0][l] <= RW'(num_d[l][NW-1:CW]);
      low_q[0][l] <= num_d[l][CW-1:0];
    end
    quo_q[0]  <= '0;
    den_q[0]  <= mden_q;
    base_q[0] <= mbase_q;
    neg_q[0]  <= mneg_q;
    hit_q[0]  <= mhit_q;
    for (int s = 0; s < NST; s++) begin
      rem_q[s + 1]  <= rem_d[s];
      quo_q[s + 1]  <= quo_d[s];
      for (int l = 0; l < LN; l++) begin
        low_q[s + 1][l] <= {low_q[s][l][CW-2:0], 1'b0};
      end
      den_q[s + 1]  <= den_q[s];
      base_q[s + 1] <= base_q[s];
      neg_q[s + 1]  <= neg_q[s];
      hit_q[s + 1]  <= hit_q[s];
    end
  end

  // round half up and apply to the base point
  logic [LN-1:0]         rnd;
  logic [LN-1:0][CW-1:0] qf;
  logic [LN-1:0][CW-1:0] seg_d;

  always_comb begin
    for (int l = 0; l < LN; l++) begin
      rnd[l]   = ({rem_q[NST][l], 1'b0} >= {1'b0, den_q[NST][l]});
      qf[l]    = quo_q[NST][l] + CW'(rnd[l]);
      seg_d[l] = neg_q[NST][l] ? (base_q[NST][l] - qf[l]) : (base_q[NST][l] + qf[l]);
    end
  end

  logic done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q[NST];
    end
  end

  always_ff @(posedge clk_i) begin
    hit_o <= hit_q[NST];
    seg_o <= seg_d;
  end

  assign done_o = done_q;

endmodule

[dv/triangle_plane_slicer_tb.sv]
// ----------------------------------------------------------------------------
// triangle_plane_slicer_tb
// Self-checking bench for the triangle/plane slicer. Triangles are pushed
// through the command port with random gaps. An exact-arithmetic predictor
// queues the expected hit flag and segment for each accepted triangle. A
// checker compares every done_o strobe against the oldest queued segment.
// The plane is rewritten between phases, only while the pipeline is empty.
// ----------------------------------------------------------------------------
module triangle_plane_slicer_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW      = 32;
  localparam int LATENCY = CW + 8;

  typedef struct packed {
    logic              hit;
    logic [2:0][CW-1:0] pa;
    logic [2:0][CW-1:0] pb;
  } segment_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [CW-1:0] vin [9];
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [tps_pkg::CFG_IDX_W-1:0] cfg_index_i = tps_pkg::CFG_NORMAL_X;
  logic [CW-1:0] cfg_data_i = '0;
  logic done_o, hit_o;
  logic [CW-1:0] seg_a_x_o, seg_a_y_o, seg_a_z_o, seg_b_x_o, seg_b_y_o, seg_b_z_o;

  // plane copy used by the predictor
  logic signed [tps_pkg::NORM_BITS-1:0] plane_n [3];
  logic signed [CW-1:0]                 plane_p [3];

  segment_t segments_due [$];
  int errors = 0;
  int triangles_sent = 0;
  int hits_seen = 0;
  int results_seen = 0;
  int planes_set = 0;
  bit no_gaps = 1'b0;

  triangle_plane_slicer #(.COORD_BITS(CW)) u_top (
    .clk_i, .rst_ni, .start, .busy,
    .v0_x_i(vin[0]), .v0_y_i(vin[1]), .v0_z_i(vin[2]),
    .v1_x_i(vin[3]), .v1_y_i(vin[4]), .v1_z_i(vin[5]),
    .v2_x_i(vin[6]), .v2_y_i(vin[7]), .v2_z_i(vin[8]),
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .done_o, .hit_o,
    .seg_a_x_o, .seg_a_y_o, .seg_a_z_o, .seg_b_x_o, .seg_b_y_o, .seg_b_z_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #400000;
    $display("timeout with %0d segments outstanding", segments_due.size());
    $display("TEST FAILED");
    $finish;
  end

  task automatic report(input string what);
    errors++;
    if (errors <= 20) $display("MISMATCH @%0t: %s", $realtime, what);
  endtask

  // point where the distance crosses zero on edge a->b, nearest step, ties away
  function automatic longint edge_cross(longint ca, longint cb, longint da, longint db);
    longint den, delta;
    logic [127:0] num, mag_den, q, r;
    bit neg;
    den   = da - db;
    delta = cb - ca;
    if (den == 0) return ca;
    num     = 128'(da < 0 ? -da : da) * 128'(delta < 0 ? -delta : delta);
    mag_den = 128'(den < 0 ? -den : den);
    q = num / mag_den;
    r = num % mag_den;
    if (r >= mag_den - r) q++;
    neg = (delta < 0) != ((da < 0) != (den < 0));
    return neg ? ca - longint'(q[63:0]) : ca + longint'(q[63:0]);
  endfunction

  function automatic segment_t slice_triangle(input logic [CW-1:0] v [9]);
    segment_t s;
    longint c [3][3];
    longint d [3];
    int sg [3];
    int lone, o1, o2, ea, eb;
    s = '0;
    lone = -1;
    for (int i = 0; i < 3; i++) begin
      d[i] = 0;
      for (int k = 0; k < 3; k++) begin
        c[i][k] = longint'($signed(v[i*3+k]));
        d[i] += longint'(plane_n[k]) * (c[i][k] - longint'(plane_p[k]));
      end
      sg[i] = (d[i] == 0) ? 0 : (d[i] < 0 ? -1 : 1);
    end
    if (sg[0] == 0 && sg[1] == 0 && sg[2] == 0) return s;
    // two vertices on the plane: that edge is the segment
    for (int i = 0; i < 3; i++) begin
      o1 = (i + 1) % 3;
      o2 = (i + 2) % 3;
      if (sg[o1] == 0 && sg[o2] == 0) begin
        ea = o1 < o2 ? o1 : o2;
        eb = o1 < o2 ? o2 : o1;
        s.hit = 1'b1;
        for (int k = 0; k < 3; k++) begin
          s.pa[k] = c[ea][k][CW-1:0];
          s.pb[k] = c[eb][k][CW-1:0];
        end
        return s;
      end
    end
    // first vertex alone on its side
    for (int i = 0; i < 3 && lone < 0; i++) begin
      o1 = (i + 1) % 3;
      o2 = (i + 2) % 3;
      if ((sg[i] >= 0 && sg[o1] <= 0 && sg[o2] <= 0) ||
          (sg[i] <= 0 && sg[o1] >= 0 && sg[o2] >= 0)) lone = i;
    end
    if (lone < 0) return s;
    ea = (lone == 2) ? 0 : 2;
    eb = (lone == 1) ? 0 : 1;
    s.hit = 1'b1;
    for (int k = 0; k < 3; k++) begin
      s.pa[k] = CW'(edge_cross(c[lone][k], c[ea][k], d[lone], d[ea]));
      s.pb[k] = CW'(edge_cross(c[lone][k], c[eb][k], d[lone], d[eb]));
    end
    return s;
  endfunction

  // result checker: done_o beat against oldest expectation
  always @(posedge clk_i) begin
    segment_t exp_s;
    if (rst_ni && done_o) begin
      results_seen++;
      if (segments_due.size() == 0) begin
        report("result with nothing expected");
      end else begin
        exp_s = segments_due.pop_front();
        if (exp_s.hit) hits_seen++;
        if (hit_o !== exp_s.hit)
          report($sformatf("hit %b exp %b", hit_o, exp_s.hit));
        if (seg_a_x_o !== exp_s.pa[0]) report($sformatf("a_x %h exp %h", seg_a_x_o, exp_s.pa[0]));
        if (seg_a_y_o !== exp_s.pa[1]) report($sformatf("a_y %h exp %h", seg_a_y_o, exp_s.pa[1]));
        if (seg_a_z_o !== exp_s.pa[2]) report($sformatf("a_z %h exp %h", seg_a_z_o, exp_s.pa[2]));
        if (seg_b_x_o !== exp_s.pb[0]) report($sformatf("b_x %h exp %h", seg_b_x_o, exp_s.pb[0]));
        if (seg_b_y_o !== exp_s.pb[1]) report($sformatf("b_y %h exp %h", seg_b_y_o, exp_s.pb[1]));
        if (seg_b_z_o !== exp_s.pb[2]) report($sformatf("b_z %h exp %h", seg_b_z_o, exp_s.pb[2]));
      end
    end
  end

  // send one triangle beat, after a random gap unless gaps are off
  task automatic send_triangle(input logic [CW-1:0] v [9]);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      @(negedge clk_i) start = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    vin   = v;
    start = 1'b1;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    segments_due.push_back(slice_triangle(v));
    triangles_sent++;
  endtask

  task automatic drain();
    @(negedge clk_i) start = 1'b0;
    while (segments_due.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [tps_pkg::CFG_IDX_W-1:0] idx,
                           input logic [CW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    if (idx <= tps_pkg::CFG_NORMAL_Z) plane_n[idx] = data[tps_pkg::NORM_BITS-1:0];
    else plane_p[idx - tps_pkg::CFG_POINT_X] = data;
    @(negedge clk_i) cfg_valid_i = 1'b0;
  endtask

  // rewrite the whole plane; upper junk bits on the normal must be ignored
  task automatic set_plane(input logic [tps_pkg::NORM_BITS-1:0] nx, ny, nz,
                           input logic [CW-1:0] px, py, pz);
    drain();
    write_reg(tps_pkg::CFG_NORMAL_X, {14'($urandom), nx});
    write_reg(tps_pkg::CFG_NORMAL_Y, {14'($urandom), ny});
    write_reg(tps_pkg::CFG_NORMAL_Z, {14'($urandom), nz});
    write_reg(tps_pkg::CFG_POINT_X, px);
    write_reg(tps_pkg::CFG_POINT_Y, py);
    write_reg(tps_pkg::CFG_POINT_Z, pz);
    planes_set++;
  endtask

  function automatic void tri_set(output logic [CW-1:0] v [9],
      input logic [CW-1:0] a0, a1, a2, b0, b1, b2, c0, c1, c2);
    v = '{a0, a1, a2, b0, b1, b2, c0, c1, c2};
  endfunction

  // directed cases on the reset plane z = 0, then on zero and extreme planes
  task automatic test_special_cases();
    logic [CW-1:0] v [9];
    localparam logic [CW-1:0] MX = 32'h7fff_ffff, MN = 32'h8000_0000, ONE = 32'h0001_0000;
    tri_set(v, 0, 0, ONE, ONE, 0, ONE, 0, ONE, 5);              send_triangle(v); // all above
    tri_set(v, 0, 0, -ONE, ONE, 0, -1, 0, ONE, MN);             send_triangle(v); // all below
    tri_set(v, 0, 0, 0, ONE, 0, 0, 0, ONE, 0);                  send_triangle(v); // in plane
    tri_set(v, 1, 2, 0, ONE, 3, 0, 5, 5, ONE);                  send_triangle(v); // edge v0-v1
    tri_set(v, 1, 2, 0, 7, 3, ONE, 5, 5, 0);                    send_triangle(v); // edge v0-v2
    tri_set(v, 1, 2, -ONE, 7, 3, 0, 5, 5, 0);                   send_triangle(v); // edge v1-v2
    tri_set(v, 9, 9, 0, 7, 3, ONE, 5, 5, ONE);                  send_triangle(v); // touch v0
    tri_set(v, 9, 9, -3, 7, 3, 0, 5, 5, -ONE);                  send_triangle(v); // touch v1
    tri_set(v, 0, 0, ONE, ONE, 0, -ONE, 0, ONE, -ONE);          send_triangle(v); // v0 alone
    tri_set(v, 0, 0, -ONE, ONE, 0, ONE, 0, ONE, -ONE);          send_triangle(v); // v1 alone
    tri_set(v, 0, 0, -ONE, ONE, 0, -ONE, 0, ONE, ONE);          send_triangle(v); // v2 alone
    tri_set(v, 0, 0, 0, ONE, 0, ONE, 0, ONE, -ONE);             send_triangle(v); // vertex through
    tri_set(v, 3, 0, 1, 0, 0, -2, 0, 0, -2);                    send_triangle(v); // v0 alone, exact quotients
    tri_set(v, MX, MN, MX, MN, MX, MN, MX, MX, MN);             send_triangle(v); // extremes
    tri_set(v, MN, MN, MN, MX, MX, MX, MN, MX, 1);              send_triangle(v);
    tri_set(v, MX, MX, 1, MN, MN, MN, 0, 0, MX);                send_triangle(v);
    // zero normal: every distance is zero
    set_plane('0, '0, '0, 0, 0, 0);
    tri_set(v, 0, 0, ONE, ONE, 0, -ONE, 0, ONE, 7);             send_triangle(v);
    // normal components of -1.0 and an extreme point
    set_plane(18'h30000, 18'h30000, 18'h30000, MX, MN, MX);
    tri_set(v, MX, MX, MX, MN, MN, MN, 0, 0, 0);                send_triangle(v);
    tri_set(v, MN, MX, 0, MX, MN, MX, MN, MN, MX);              send_triangle(v);
    set_plane(18'h1ffff, 18'h20000, 18'h1ffff, MN, MX, MN);
    tri_set(v, MX, MX, MX, MN, MN, MN, 0, 0, 0);                send_triangle(v);
    tri_set(v, MN, MX, 0, MX, MN, MX, MN, MN, MX);              send_triangle(v);
  endtask

  // random triangles, most clustered near the plane, some snapped onto it
  task automatic test_random_phase(input int count, input int snap_axis);
    logic [CW-1:0] v [9];
    int span;
    for (int n = 0; n < count; n++) begin
      if (n % 97 == 0) no_gaps = ~no_gaps;
      if ($urandom_range(0, 9) < 2) begin
        foreach (v[j]) v[j] = $urandom;
      end else begin
        span = $urandom_range(4, 24);
        foreach (v[j]) begin
          v[j] = plane_p[j % 3] + CW'($signed($urandom_range(0, (1 << span) - 1))
                 - (1 << (span - 1)));
          if (snap_axis == j % 3 && $urandom_range(0, 2) == 0) v[j] = plane_p[j % 3];
        end
      end
      send_triangle(v);
      // hold off once until the pipeline is empty
      if (n == count / 2) drain();
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_random_planes();
    logic [tps_pkg::NORM_BITS-1:0] nn [3];
    set_plane(18'h10000, '0, '0, $urandom, $urandom, $urandom);
    test_random_phase(200, 0);
    set_plane('0, 18'h30000, '0, $urandom, $urandom, $urandom);
    test_random_phase(200, 1);
    set_plane('0, '0, 18'h30000, 32'h7fff_ffff, 32'h8000_0000, $urandom);
    test_random_phase(200, 2);
    for (int p = 0; p < 6; p++) begin
      foreach (nn[k]) nn[k] = $urandom_range(0, 3) == 0 ? '0 : tps_pkg::NORM_BITS'($urandom);
      set_plane(nn[0], nn[1], nn[2], $urandom, $urandom, $urandom);
      test_random_phase(160, -1);
    end
  endtask

  initial begin
    foreach (vin[j]) vin[j] = '0;
    plane_n = '{'0, '0, tps_pkg::NORMAL_Z_RESET};
    plane_p = '{'0, '0, '0};
    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    test_special_cases();
    test_random_planes();
    drain();
    $display("Sliced %0d triangles (%0d results, %0d hits) over %0d plane settings",
             triangles_sent, results_seen, hits_seen, planes_set);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
